>>> rtl/horizontal_box_blur_row_core_defines.svh
// assertion macros for the horizontal box blur row core
`ifndef HORIZONTAL_BOX_BLUR_ROW_CORE_DEFINES_SVH
`define HORIZONTAL_BOX_BLUR_ROW_CORE_DEFINES_SVH

// same-cycle implication
`define HBB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbb same-cycle check failed");

// next-cycle implication
`define HBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbb next-cycle check failed");

`endif

>>> rtl/hbb_pkg.sv
// shared constants and types of the horizontal box blur row core
`timescale 1ns / 1ps
package hbb_pkg;

   localparam int PIXEL_W          = 8;
   localparam int PIXEL_MAX        = (1 << PIXEL_W) - 1;
   localparam int ROW_WIDTH_W      = 13;
   localparam int HALF_WIDTH_W     = 5;
   localparam int CSR_DATA_W       = 13;
   localparam int CSR_INDEX_W      = 1;
   localparam int QUEUE_DEPTH      = 4;

   localparam int DEF_MAX_HALF_WIDTH = 16;
   localparam int DEF_MAX_ROW_WIDTH  = 4096;

   localparam logic [ROW_WIDTH_W-1:0]  ROW_WIDTH_RESET  = 13'd640;
   localparam logic [HALF_WIDTH_W-1:0] HALF_WIDTH_RESET = 5'd1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_WIDTH = 1'b1;

   typedef struct packed {
      logic first;
      logic last;
   } step_flags_type;

endpackage

>>> rtl/hbb_front.sv
// front end: accepts pixels, tracks the column and classifies each transaction
`timescale 1ns / 1ps
module hbb_front #(
   parameter int MAX_HALF_WIDTH = 16,
   parameter int MAX_ROW_WIDTH  = 4096
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      restart,
   input  logic [$clog2(MAX_ROW_WIDTH)-1:0]          row_last,
   input  logic [$clog2(MAX_HALF_WIDTH + 1)-1:0]     half_eff,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [hbb_pkg::PIXEL_W-1:0]               req_pixel_in,
   input  logic                                      push_ready,
   output logic                                      push_valid,
   output logic [hbb_pkg::PIXEL_W-1:0]               push_pixel,
   output logic [$clog2(MAX_HALF_WIDTH + 1)-1:0]     push_skip,
   output hbb_pkg::step_flags_type                   push_flags
);
   import hbb_pkg::*;

   localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
   localparam int HALF_W = $clog2(MAX_HALF_WIDTH + 1);

   logic [COL_W-1:0] column_ff;
   logic [COL_W-1:0] column_in;
   logic [COL_W-1:0] col;
   logic             accept;

   assign req_stall  = !push_ready;
   assign accept     = req_valid && push_ready;
   assign push_valid = accept;
   assign push_pixel = req_pixel_in;

   always_comb begin
      col = (column_ff > row_last) ? row_last : column_ff;
      push_flags.first = (col == '0);
      push_flags.last  = (col == row_last);
      // steps of a transaction, the row end flush included, that still fall left of the row
      if (32'(col) < 32'(half_eff)) begin
         push_skip = HALF_W'(32'(half_eff) - 32'(col));
      end else begin
         push_skip = '0;
      end
      column_in = column_ff;
      if (restart) begin
         column_in = '0;
      end else if (accept) begin
         column_in = push_flags.last ? '0 : COL_W'(col + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else begin
         column_ff <= column_in;
      end
   end

endmodule

>>> rtl/hbb_queue.sv
// short command queue between the front end and the back end
`timescale 1ns / 1ps
module hbb_queue #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/hbb_back.sv
// back end: window shift line, running sum, reciprocal divide and result register
`timescale 1ns / 1ps
module hbb_back #(
   parameter int MAX_HALF_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [$clog2(MAX_HALF_WIDTH + 1)-1:0] half_eff,
   input  logic                                  q_valid,
   input  logic [hbb_pkg::PIXEL_W-1:0]           q_pixel,
   input  logic [$clog2(MAX_HALF_WIDTH + 1)-1:0] q_skip,
   input  hbb_pkg::step_flags_type               q_flags,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hbb_pkg::PIXEL_W-1:0]           rsp_pixel_out,
   output logic                                  rsp_row_end
);
   import hbb_pkg::*;

   localparam int HALF_W  = $clog2(MAX_HALF_WIDTH + 1);
   localparam int TAPS    = 2 * MAX_HALF_WIDTH + 1;
   localparam int TAP_W   = $clog2(TAPS);
   localparam int DIV_W   = HALF_W + 1;
   localparam int SUM_W   = $clog2(TAPS * PIXEL_MAX + 1);
   localparam int SHIFT   = SUM_W + DIV_W;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int LOAD_W  = DIV_W + PIXEL_W;

   // reciprocal of each window length, rounded up
   logic [RECIP_W-1:0] recip_table [MAX_HALF_WIDTH + 1];

   for (genvar g = 0; g <= MAX_HALF_WIDTH; g++) begin : g_recip
      localparam longint unsigned RECIP =
         ((64'd1 << SHIFT) + 64'(2 * g)) / 64'(2 * g + 1);
      assign recip_table[g] = RECIP_W'(RECIP);
   end

   logic                 busy_ff, busy_in;
   logic [HALF_W-1:0]    k_ff, k_in;
   logic [PIXEL_W-1:0]   cmd_pixel_ff, cmd_pixel_in;
   logic [HALF_W-1:0]    cmd_skip_ff, cmd_skip_in;
   step_flags_type       cmd_flags_ff, cmd_flags_in;
   logic [PIXEL_W-1:0]   taps_ff [TAPS];
   logic [PIXEL_W-1:0]   taps_in [TAPS];
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_end_ff, s1_end_in;
   logic [RECIP_W-1:0]   recip_ff, recip_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_end_ff, s2_end_in;
   logic                 out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]   out_pixel_ff, out_pixel_in;
   logic                 out_end_ff, out_end_in;

   logic                 advance;
   logic                 final_step;
   logic                 take;
   logic                 step;
   logic                 loading;
   logic [HALF_W:0]      two_r;
   logic [DIV_W-1:0]     divisor;
   logic [PIXEL_W-1:0]   oldest;
   logic [LOAD_W-1:0]    load_prod;

   assign advance    = !out_valid_ff || !rsp_stall;
   assign final_step = !cmd_flags_ff.last || (k_ff == half_eff);
   assign take       = advance && (!busy_ff || final_step) && q_valid;
   assign step       = advance && busy_ff;
   assign loading    = cmd_flags_ff.first && (k_ff == '0);
   assign two_r      = {half_eff, 1'b0};
   assign divisor    = {half_eff, 1'b1};
   assign oldest     = taps_ff[TAP_W'(two_r)];
   assign load_prod  = LOAD_W'(divisor) * LOAD_W'(cmd_pixel_ff);

   assign q_pop         = take;
   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_row_end   = out_end_ff;

   always_comb begin
      busy_in      = busy_ff;
      k_in         = k_ff;
      cmd_pixel_in = cmd_pixel_ff;
      cmd_skip_in  = cmd_skip_ff;
      cmd_flags_in = cmd_flags_ff;
      taps_in      = taps_ff;
      sum_in       = sum_ff;
      s1_valid_in  = s1_valid_ff;
      s1_end_in    = s1_end_ff;
      prod_in      = prod_ff;
      s2_valid_in  = s2_valid_ff;
      s2_end_in    = s2_end_ff;
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_end_in   = out_end_ff;
      recip_in     = recip_table[half_eff];

      if (advance) begin
         // window step for the current transaction
         s1_valid_in = 1'b0;
         s1_end_in   = 1'b0;
         if (step) begin
            if (loading) begin
               for (int i = 0; i < TAPS; i++) begin
                  taps_in[i] = cmd_pixel_ff;
               end
               sum_in = SUM_W'(load_prod);
            end else begin
               taps_in[0] = cmd_pixel_ff;
               for (int i = 1; i < TAPS; i++) begin
                  taps_in[i] = taps_ff[i-1];
               end
               sum_in = SUM_W'(32'(sum_ff) + 32'(cmd_pixel_ff) - 32'(oldest));
            end
            s1_valid_in = (k_ff >= cmd_skip_ff);
            s1_end_in   = cmd_flags_ff.last && (k_ff == half_eff);
            k_in        = HALF_W'(k_ff + 1'b1);
         end
         if (!busy_ff || final_step) begin
            busy_in = q_valid;
         end
         if (take) begin
            cmd_pixel_in = q_pixel;
            cmd_skip_in  = q_skip;
            cmd_flags_in = q_flags;
            k_in         = '0;
         end

         // divide by the window length
         prod_in     = PROD_W'(sum_ff) * PROD_W'(recip_ff);
         s2_valid_in = s1_valid_ff;
         s2_end_in   = s1_end_ff;

         out_pixel_in = prod_ff[SHIFT +: PIXEL_W];
         out_valid_in = s2_valid_ff;
         out_end_in   = s2_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      cmd_pixel_ff <= cmd_pixel_in;
      cmd_skip_ff  <= cmd_skip_in;
      cmd_flags_ff <= cmd_flags_in;
      taps_ff      <= taps_in;
      sum_ff       <= sum_in;
      s1_end_ff    <= s1_end_in;
      recip_ff     <= recip_in;
      prod_ff      <= prod_in;
      s2_end_ff    <= s2_end_in;
      out_pixel_ff <= out_pixel_in;
      out_end_ff   <= out_end_in;
   end

endmodule

>>> rtl/horizontal_box_blur_row_core.sv
// Horizontal box blur over one row, one pixel per transaction, edge pixels repeated.
// The result for column x leaves only after the pixel of column x+r has been taken.
// Throughput: one pixel per cycle while rsp_stall is low; the last pixel of a row holds the
// window step unit to flush the row, next pixels wait in the 4 entry queue, stall when full.
// Reset (synchronous, active high) empties the queue and pipeline, restarts the row
// and sets row_width to 640 and half_width to 1.
`timescale 1ns / 1ps
`include "horizontal_box_blur_row_core_defines.svh"
module horizontal_box_blur_row_core #(
   parameter int MAX_HALF_WIDTH = hbb_pkg::DEF_MAX_HALF_WIDTH,
   parameter int MAX_ROW_WIDTH  = hbb_pkg::DEF_MAX_ROW_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hbb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hbb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [hbb_pkg::PIXEL_W-1:0]      req_pixel_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [hbb_pkg::PIXEL_W-1:0]      rsp_pixel_out,
   output logic                             rsp_row_end
);
   import hbb_pkg::*;

   localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
   localparam int HALF_W = $clog2(MAX_HALF_WIDTH + 1);
   localparam int FLAG_W = $bits(step_flags_type);
   localparam int CMD_W  = PIXEL_W + HALF_W + FLAG_W;

   logic [ROW_WIDTH_W-1:0]  row_width_ff, row_width_in;
   logic [HALF_WIDTH_W-1:0] half_width_ff, half_width_in;
   logic [COL_W-1:0]        row_last;
   logic [HALF_W-1:0]       half_eff;

   logic                    q_push;
   logic                    q_ready;
   logic                    q_valid;
   logic                    q_pop;
   logic [PIXEL_W-1:0]      push_pixel;
   logic [HALF_W-1:0]       push_skip;
   step_flags_type          push_flags;
   logic [CMD_W-1:0]        push_cmd;
   logic [CMD_W-1:0]        pop_cmd;
   logic [PIXEL_W-1:0]      pop_pixel;
   logic [HALF_W-1:0]       pop_skip;
   step_flags_type          pop_flags;

   // configuration registers
   always_comb begin
      row_width_in  = row_width_ff;
      half_width_in = half_width_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ROW_WIDTH: begin
               row_width_in = csr_wdata[ROW_WIDTH_W-1:0];
            end
            REG_HALF_WIDTH: begin
               half_width_in = csr_wdata[HALF_WIDTH_W-1:0];
            end
            default: begin
               row_width_in = row_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= ROW_WIDTH_RESET;
         half_width_ff <= HALF_WIDTH_RESET;
      end else begin
         row_width_ff  <= row_width_in;
         half_width_ff <= half_width_in;
      end
   end

   always_comb begin
      if (row_width_ff == '0) begin
         row_last = '0;
      end else if (32'(row_width_ff) > 32'(MAX_ROW_WIDTH)) begin
         row_last = COL_W'(MAX_ROW_WIDTH - 1);
      end else begin
         row_last = COL_W'(32'(row_width_ff) - 32'd1);
      end
      if (32'(half_width_ff) > 32'(MAX_HALF_WIDTH)) begin
         half_eff = HALF_W'(MAX_HALF_WIDTH);
      end else begin
         half_eff = HALF_W'(half_width_ff);
      end
   end

   hbb_front #(
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
      .MAX_ROW_WIDTH  (MAX_ROW_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_we),
      .row_last     (row_last),
      .half_eff     (half_eff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel_in (req_pixel_in),
      .push_ready   (q_ready),
      .push_valid   (q_push),
      .push_pixel   (push_pixel),
      .push_skip    (push_skip),
      .push_flags   (push_flags)
   );

   assign push_cmd = {push_pixel, push_skip, push_flags};

   hbb_queue #(
      .DATA_W (CMD_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_data  (push_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (pop_cmd)
   );

   assign {pop_pixel, pop_skip, pop_flags} = pop_cmd;

   hbb_back #(
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .half_eff      (half_eff),
      .q_valid       (q_valid),
      .q_pixel       (pop_pixel),
      .q_skip        (pop_skip),
      .q_flags       (pop_flags),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end)
   );

   // stall only while the queue holds commands
   `HBB_ASSERT_NOW(a_stall_queue_full, clock, reset, req_stall, q_valid)
   // after a push the queue holds a command ready to pop on the next cycle
   `HBB_ASSERT_NEXT(a_push_visible, clock, reset, q_push, q_valid)
   // the first column skips the whole left half of the window
   `HBB_ASSERT_NOW(a_first_skip, clock, reset, q_push && push_flags.first, push_skip == half_eff)
   `HBB_ASSERT_NOW(a_skip_bound, clock, reset, q_push, push_skip <= half_eff)

endmodule

>>> tb/hbb_checker.sv
// checker for the horizontal box blur row core: predicts blurred pixels and compares results
`timescale 1ns / 1ps
module hbb_checker #(
   parameter int MAX_HALF_WIDTH = hbb_pkg::DEF_MAX_HALF_WIDTH,
   parameter int MAX_ROW_WIDTH  = hbb_pkg::DEF_MAX_ROW_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [hbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hbb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [hbb_pkg::PIXEL_W-1:0]     req_pixel_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [hbb_pkg::PIXEL_W-1:0]     rsp_pixel_out,
   input  logic                            rsp_row_end,
   output int                              failures,
   output int                              pending,
   output int                              checked
);
   import hbb_pkg::*;

   localparam int STORE_DEPTH = 2 * MAX_HALF_WIDTH + 1;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
   } blur_pixel_type;

   blur_pixel_type           blurred_q[$];
   logic [PIXEL_W-1:0]       row_store [STORE_DEPTH];
   logic [ROW_WIDTH_W-1:0]   width_reg;
   logic [HALF_WIDTH_W-1:0]  half_reg;
   int unsigned              in_col;
   int unsigned              out_col;
   int                       fail_tally = 0;
   int                       result_tally = 0;

   task automatic predict_row_blur(input logic [PIXEL_W-1:0] pix);
      int unsigned w;
      int unsigned r;
      int unsigned col;
      int unsigned last;
      int unsigned target;
      int unsigned x;
      int unsigned k;
      int unsigned pos;
      int unsigned sum;
      blur_pixel_type res;
      w = 32'(width_reg);
      if (w == 0) w = 1;
      if (w > MAX_ROW_WIDTH) w = MAX_ROW_WIDTH;
      r = 32'(half_reg);
      if (r > MAX_HALF_WIDTH) r = MAX_HALF_WIDTH;
      last = w - 1;
      col = in_col;
      if (col > last) col = last;
      row_store[col % STORE_DEPTH] = pix;
      if (col == last) begin
         target = w;
      end else if (col >= r) begin
         target = col - r + 1;
      end else begin
         target = 0;
      end
      while (out_col < target) begin
         x = out_col;
         sum = 0;
         for (k = 0; k <= 2 * r; k++) begin
            pos = (x + k < r) ? 0 : x + k - r;
            if (pos > col) pos = col;
            sum += 32'(row_store[pos % STORE_DEPTH]);
         end
         res.pixel = PIXEL_W'(sum / (2 * r + 1));
         res.row_end = (x == last);
         blurred_q.push_back(res);
         out_col++;
      end
      if (col == last) begin
         in_col = 0;
         out_col = 0;
      end else begin
         in_col = col + 1;
      end
   endtask

   always @(posedge clock) begin
      blur_pixel_type got;
      blur_pixel_type want;
      if (reset) begin
         width_reg = ROW_WIDTH_RESET;
         half_reg = HALF_WIDTH_RESET;
         foreach (row_store[i]) row_store[i] = '0;
         in_col = 0;
         out_col = 0;
         blurred_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_ROW_WIDTH) begin
               width_reg = csr_wdata[ROW_WIDTH_W-1:0];
            end else if (csr_index == REG_HALF_WIDTH) begin
               half_reg = csr_wdata[HALF_WIDTH_W-1:0];
            end
            // any write restarts the row
            in_col = 0;
            out_col = 0;
         end
         if (req_valid && !req_stall) predict_row_blur(req_pixel_in);
         if (rsp_valid && !rsp_stall) begin
            got.pixel = rsp_pixel_out;
            got.row_end = rsp_row_end;
            result_tally++;
            if (blurred_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got pixel_out %0d row_end %0d",
                        $time, got.pixel, got.row_end);
               fail_tally++;
            end else begin
               want = blurred_q.pop_front();
               if (got.pixel !== want.pixel) begin
                  $display("%0t: pixel_out expected %0d, got %0d",
                           $time, want.pixel, got.pixel);
                  fail_tally++;
               end
               if (got.row_end !== want.row_end) begin
                  $display("%0t: row_end expected %0d, got %0d",
                           $time, want.row_end, got.row_end);
                  fail_tally++;
               end
            end
         end
      end
      failures <= fail_tally;
      pending <= blurred_q.size();
      checked <= result_tally;
   end

endmodule

>>> tb/tb_horizontal_box_blur_row_core.sv
// testbench top for the horizontal box blur row core: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_horizontal_box_blur_row_core;
   import hbb_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_PIXELS = 150;
   localparam int JUNK_W        = CSR_DATA_W - HALF_WIDTH_W;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]     rsp_pixel_out;
   logic                   rsp_row_end;

   int failures;
   int pending;
   int checked;
   bit no_idle = 1'b0;
   int rsp_hold = 0;
   int quiet_cycles = 0;
   int pixel_total = 0;
   int setting_total = 0;

   horizontal_box_blur_row_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end)
   );

   hbb_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side back-pressure
   always @(posedge clock) begin
      int stall_draw;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = no_idle ? 0 : $urandom_range(0, 6);
         rsp_stall <= (stall_draw != 0);
         rsp_hold <= (stall_draw != 0) ? stall_draw - 1 : 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= no_idle ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixel_total++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [ROW_WIDTH_W-1:0] width,
                            input logic [HALF_WIDTH_W-1:0] half);
      logic [JUNK_W-1:0] junk;
      settle();
      junk = JUNK_W'($urandom);
      csr_we <= 1'b1;
      csr_index <= REG_ROW_WIDTH;
      csr_wdata <= width;
      @(posedge clock);
      csr_index <= REG_HALF_WIDTH;
      csr_wdata <= {junk, half};
      @(posedge clock);
      csr_we <= 1'b0;
      setting_total++;
   endtask

   initial begin
      int n;
      int pick;
      int mode;
      int random_sent;
      logic [ROW_WIDTH_W-1:0]  w;
      logic [HALF_WIDTH_W-1:0] r;
      logic [PIXEL_W-1:0]      p;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings, mid-row
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd128);
      send_pixel(8'd255);
      // zero row width, no window
      configure(13'd0, 5'd0);
      send_pixel(8'd0);
      send_pixel(8'd255);
      // one pixel rows, oversized half width
      configure(13'd1, 5'd31);
      send_pixel(8'd255);
      send_pixel(8'd7);
      // row narrower than the half width
      configure(13'd3, 5'd5);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd255);
      // full-scale sums
      configure(13'd5, 5'd2);
      repeat (5) send_pixel(8'd255);
      // oversized row width
      configure(13'd8191, 5'd1);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd0);

      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         if (random_sent == 0) begin
            w = 13'd4096;
            r = 5'd16;
            n = 40;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               w = ROW_WIDTH_W'($urandom_range(0, 8191));
            end else begin
               w = ROW_WIDTH_W'($urandom_range(1, 24));
            end
            pick = $urandom_range(0, 7);
            case (pick)
               0: r = 5'd0;
               1: r = HALF_WIDTH_W'($urandom_range(17, 31));
               2: r = 5'd16;
               default: r = HALF_WIDTH_W'($urandom_range(1, 8));
            endcase
            if (w <= 24) begin
               n = int'(w) * int'($urandom_range(1, 3)) + int'($urandom_range(1, 3));
            end else begin
               n = $urandom_range(20, 40);
            end
            if (n > 60) n = 60;
         end
         if (n > RANDOM_PIXELS - random_sent) n = RANDOM_PIXELS - random_sent;
         mode = $urandom_range(0, 3);
         configure(w, r);
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (n) begin
            case (mode)
               0: p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
               1: p = 8'd255;
               default: p = PIXEL_W'($urandom);
            endcase
            send_pixel(p);
         end
         random_sent += n;
      end

      no_idle = 1'b0;
      settle();
      $display("%0d pixels sent over %0d register settings, %0d blurred pixels checked",
               pixel_total, setting_total, checked);
      if (failures == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> horizontal_box_blur_row_core.f
+incdir+rtl
rtl/hbb_pkg.sv
rtl/hbb_front.sv
rtl/hbb_queue.sv
rtl/hbb_back.sv
rtl/horizontal_box_blur_row_core.sv
tb/hbb_checker.sv
tb/tb_horizontal_box_blur_row_core.sv
